// ===== rtl/i2c_adc_channel_read_master_top_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef I2C_ADC_CHANNEL_READ_MASTER_TOP_MACROS_SVH
`define I2C_ADC_CHANNEL_READ_MASTER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define IACRM_ASSERT_NOW(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("iacrm assertion failed");

// Next-cycle implication, checked outside reset.
`define IACRM_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("iacrm assertion failed");

`else

`define IACRM_ASSERT_NOW(label, clk, rst_n, a, b)
`define IACRM_ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

// ===== rtl/iacrm_pkg.sv =====
`default_nettype none

package iacrm_pkg;

	typedef enum logic [19:0] {
		PH_IDLE   = 20'h00001,
		PH_ST_A   = 20'h00002,
		PH_ST_B   = 20'h00004,
		PH_ST_C   = 20'h00008,
		PH_ST_D   = 20'h00010,
		PH_WR_BIT = 20'h00020,
		PH_WR_HI  = 20'h00040,
		PH_WR_LO  = 20'h00080,
		PH_WR_E1  = 20'h00100,
		PH_WR_E2  = 20'h00200,
		PH_ACK_HI = 20'h00400,
		PH_ACK_PL = 20'h00800,
		PH_RD_REL = 20'h01000,
		PH_RD_HI  = 20'h02000,
		PH_RD_LO  = 20'h04000,
		PH_RD_E1  = 20'h08000,
		PH_RD_E2  = 20'h10000,
		PH_SP_A   = 20'h20000,
		PH_SP_B   = 20'h40000,
		PH_SP_C   = 20'h80000
	} phase_t;

	localparam logic [2:0] STG_ADDR_W  = 3'd0;
	localparam logic [2:0] STG_CTRL    = 3'd1;
	localparam logic [2:0] STG_CTRL_AK = 3'd2;
	localparam logic [2:0] STG_RESTART = 3'd3;
	localparam logic [2:0] STG_ADDR_R  = 3'd4;
	localparam logic [2:0] STG_READ    = 3'd5;
	localparam logic [2:0] STG_STOP    = 3'd6;

	localparam logic [2:0] LAST_BIT = 3'd7;

	localparam logic CFG_DEVICE_ADDRESS = 1'b0;
	localparam logic CFG_ACK_POLL_LIMIT = 1'b1;

	localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd72;
	localparam logic [7:0] ACK_POLL_LIMIT_RESET = 8'd255;

	typedef struct packed {
		logic       start_request;
		logic [7:0] control_byte;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic [6:0] device_address;
		logic [7:0] ack_poll_limit;
	} cfg_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_missing;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/iacrm_seq.sv =====
`default_nettype none

`include "i2c_adc_channel_read_master_top_macros.svh"

module iacrm_seq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire iacrm_pkg::item_t item,
	input  wire iacrm_pkg::cfg_t  cfg,
	output iacrm_pkg::res_t       res
);

	iacrm_pkg::phase_t phase_q, phase_d;
	logic [2:0] bit_q, bit_d;
	logic [2:0] stage_q, stage_d;
	logic [7:0] shift_q, shift_d;
	logic [7:0] ctrl_q, ctrl_d;
	logic [7:0] poll_q, poll_d;
	logic       fail_q, fail_d;
	logic       scl_q, scl_d;
	logic       sda_q, sda_d;
	logic       done_d;
	logic [7:0] addr_w;

	assign addr_w = {cfg.device_address, 1'b0};

	always_comb begin
		phase_d = phase_q;
		bit_d   = bit_q;
		stage_d = stage_q;
		shift_d = shift_q;
		ctrl_d  = ctrl_q;
		poll_d  = poll_q;
		fail_d  = fail_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		done_d  = 1'b0;
		case (phase_q)
			iacrm_pkg::PH_IDLE: begin
				if (item.start_request) begin
					ctrl_d  = item.control_byte;
					fail_d  = 1'b0;
					stage_d = iacrm_pkg::STG_ADDR_W;
					bit_d   = 3'd0;
					sda_d   = 1'b1;
					phase_d = iacrm_pkg::PH_ST_B;
				end
			end
			iacrm_pkg::PH_ST_A: begin
				sda_d   = 1'b1;
				phase_d = iacrm_pkg::PH_ST_B;
			end
			iacrm_pkg::PH_ST_B: begin
				scl_d   = 1'b1;
				phase_d = iacrm_pkg::PH_ST_C;
			end
			iacrm_pkg::PH_ST_C: begin
				sda_d   = 1'b0;
				phase_d = iacrm_pkg::PH_ST_D;
			end
			iacrm_pkg::PH_ST_D: begin
				scl_d = 1'b0;
				if (stage_q == iacrm_pkg::STG_ADDR_W) begin
					shift_d = addr_w;
					stage_d = iacrm_pkg::STG_CTRL;
				end else begin
					shift_d = addr_w | 8'h01;
					stage_d = iacrm_pkg::STG_ADDR_R;
				end
				bit_d   = 3'd0;
				phase_d = iacrm_pkg::PH_WR_BIT;
			end
			iacrm_pkg::PH_WR_BIT: begin
				sda_d   = shift_q[7];
				shift_d = {shift_q[6:0], 1'b0};
				phase_d = iacrm_pkg::PH_WR_HI;
			end
			iacrm_pkg::PH_WR_HI: begin
				scl_d   = 1'b1;
				phase_d = iacrm_pkg::PH_WR_LO;
			end
			iacrm_pkg::PH_WR_LO: begin
				scl_d = 1'b0;
				if (bit_q == iacrm_pkg::LAST_BIT) begin
					bit_d   = 3'd0;
					phase_d = iacrm_pkg::PH_WR_E1;
				end else begin
					bit_d   = bit_q + 3'd1;
					phase_d = iacrm_pkg::PH_WR_BIT;
				end
			end
			iacrm_pkg::PH_WR_E1: begin
				sda_d   = 1'b1;
				phase_d = iacrm_pkg::PH_WR_E2;
			end
			iacrm_pkg::PH_WR_E2: begin
				scl_d   = 1'b0;
				phase_d = iacrm_pkg::PH_ACK_HI;
			end
			iacrm_pkg::PH_ACK_HI: begin
				scl_d   = 1'b1;
				poll_d  = cfg.ack_poll_limit;
				phase_d = iacrm_pkg::PH_ACK_PL;
			end
			iacrm_pkg::PH_ACK_PL: begin
				if (item.sda_in && (poll_q != 8'd0)) begin
					poll_d = poll_q - 8'd1;
				end else begin
					if (item.sda_in) begin
						fail_d = 1'b1;
					end
					scl_d = 1'b0;
					case (stage_q)
						iacrm_pkg::STG_CTRL: begin
							shift_d = ctrl_q;
							stage_d = iacrm_pkg::STG_CTRL_AK;
							bit_d   = 3'd0;
							phase_d = iacrm_pkg::PH_WR_BIT;
						end
						iacrm_pkg::STG_CTRL_AK: begin
							stage_d = iacrm_pkg::STG_RESTART;
							phase_d = iacrm_pkg::PH_ST_A;
						end
						iacrm_pkg::STG_ADDR_R: begin
							stage_d = iacrm_pkg::STG_READ;
							phase_d = iacrm_pkg::PH_RD_REL;
						end
						default: begin
							phase_d = iacrm_pkg::PH_SP_A;
						end
					endcase
				end
			end
			iacrm_pkg::PH_RD_REL: begin
				sda_d   = 1'b1;
				bit_d   = 3'd0;
				phase_d = iacrm_pkg::PH_RD_HI;
			end
			iacrm_pkg::PH_RD_HI: begin
				scl_d   = 1'b1;
				phase_d = iacrm_pkg::PH_RD_LO;
			end
			iacrm_pkg::PH_RD_LO: begin
				shift_d = {shift_q[6:0], item.sda_in};
				scl_d   = 1'b0;
				if (bit_q == iacrm_pkg::LAST_BIT) begin
					bit_d   = 3'd0;
					phase_d = iacrm_pkg::PH_RD_E1;
				end else begin
					bit_d   = bit_q + 3'd1;
					phase_d = iacrm_pkg::PH_RD_HI;
				end
			end
			iacrm_pkg::PH_RD_E1: begin
				sda_d   = 1'b1;
				phase_d = iacrm_pkg::PH_RD_E2;
			end
			iacrm_pkg::PH_RD_E2: begin
				scl_d   = 1'b0;
				stage_d = iacrm_pkg::STG_STOP;
				phase_d = iacrm_pkg::PH_SP_A;
			end
			iacrm_pkg::PH_SP_A: begin
				sda_d   = 1'b0;
				phase_d = iacrm_pkg::PH_SP_B;
			end
			iacrm_pkg::PH_SP_B: begin
				scl_d   = 1'b1;
				phase_d = iacrm_pkg::PH_SP_C;
			end
			iacrm_pkg::PH_SP_C: begin
				sda_d   = 1'b1;
				done_d  = 1'b1;
				stage_d = iacrm_pkg::STG_ADDR_W;
				phase_d = iacrm_pkg::PH_IDLE;
			end
			default: begin
				scl_d   = 1'b1;
				sda_d   = 1'b1;
				phase_d = iacrm_pkg::PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= iacrm_pkg::PH_IDLE;
			bit_q   <= 3'd0;
			stage_q <= iacrm_pkg::STG_ADDR_W;
			shift_q <= 8'd0;
			ctrl_q  <= 8'd0;
			poll_q  <= 8'd0;
			fail_q  <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
		end else if (step) begin
			phase_q <= phase_d;
			bit_q   <= bit_d;
			stage_q <= stage_d;
			shift_q <= shift_d;
			ctrl_q  <= ctrl_d;
			poll_q  <= poll_d;
			fail_q  <= fail_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
		end
	end

	assign res.scl_out     = scl_d;
	assign res.sda_out     = sda_d;
	assign res.busy_res    = (phase_d != iacrm_pkg::PH_IDLE);
	assign res.done_res    = done_d;
	assign res.read_data   = done_d ? shift_d : 8'd0;
	assign res.ack_missing = fail_d;

	`IACRM_ASSERT_NEXT(a_hold_when_stalled, clk, arst_n, !step, $stable(phase_q) && $stable(shift_q))
	`IACRM_ASSERT_NEXT(a_stop_releases_lines, clk, arst_n,
		step && (phase_q == iacrm_pkg::PH_SP_C), scl_q && sda_q && (phase_q == iacrm_pkg::PH_IDLE))
	`IACRM_ASSERT_NEXT(a_fail_set_only_by_poll, clk, arst_n,
		step && !fail_q && (phase_q != iacrm_pkg::PH_ACK_PL), !fail_q)
	`IACRM_ASSERT_NOW(a_scl_low_on_data_change, clk, arst_n,
		step && (phase_q == iacrm_pkg::PH_WR_BIT), !scl_q)

endmodule

`default_nettype wire

// ===== rtl/i2c_adc_channel_read_master_top.sv =====
// Tick-driven I2C master for one combined write/read transaction with a converter.
// Each input transfer is one bus tick and yields exactly one result transfer with the
// SCL/SDA levels after that tick's line event; a new tick can be taken every clock
// while the output is not stalled, and each result passes the input register and
// then the result register. The one-tick-per-clock rate is set by the single sequencer
// state update between the input register and the result register. A request starts
// the sequence only when idle; done_res marks the tick that releases SDA at the stop,
// with read_data valid on that tick only. Write configuration only while idle.

`default_nettype none

`include "i2c_adc_channel_read_master_top_macros.svh"

module i2c_adc_channel_read_master_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// start_request[0], control_byte[8:1], sda_in[9], zero[15:10]
	input  wire logic [15:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// scl_out[0], sda_out[1], busy_res[2], done_res[3], read_data[11:4],
	// ack_missing[12], zero[15:13]
	output logic [15:0]      m_tdata,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data
);

	iacrm_pkg::cfg_t  cfg_q;
	iacrm_pkg::item_t item_s1;
	logic             valid_s1;
	iacrm_pkg::res_t  res;
	logic             advance;
	logic             out_valid_s2;
	logic [15:0]      data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address <= iacrm_pkg::DEVICE_ADDRESS_RESET;
			cfg_q.ack_poll_limit <= iacrm_pkg::ACK_POLL_LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				iacrm_pkg::CFG_DEVICE_ADDRESS: cfg_q.device_address <= cfg_data[6:0];
				iacrm_pkg::CFG_ACK_POLL_LIMIT: cfg_q.ack_poll_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.start_request <= s_tdata[0];
			item_s1.control_byte  <= s_tdata[8:1];
			item_s1.sda_in        <= s_tdata[9];
		end
	end

	iacrm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= {3'b000, res.ack_missing, res.read_data, res.done_res,
				res.busy_res, res.sda_out, res.scl_out};
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = data_s2;

	`IACRM_ASSERT_NEXT(a_stalled_item_kept, clk, arst_n, valid_s1 && !advance, valid_s1)

endmodule

`default_nettype wire
